[design/nps_pkg.sv]
`default_nettype none

package nps_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int NUM_COLORS_W      = 9;
    localparam int CHAN_W            = 8;
    localparam int ENTRY_W           = 3 * CHAN_W;
    localparam int REQ_W             = 2;
    localparam int SQ_W              = 2 * CHAN_W;
    localparam int DIST_W            = SQ_W + 2;

    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FIND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic read_start;
        logic read_done;
        logic scan_start;
        logic scan_issue;
        logic find_empty;
        logic find_done;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic pipe_busy;
    } t_status;

endpackage

`default_nettype wire

[design/nps_ram.sv]
`default_nettype none

module nps_ram #(
    parameter  int WIDTH = 24,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/nps_ctrl.sv]
`default_nettype none

module nps_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [nps_pkg::REQ_W-1:0]     i_req_type,
    output logic                               o_stall,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    input  wire nps_pkg::t_status              i_status,
    output nps_pkg::t_cmd                      o_cmd
);

    import nps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_req_type)
                        REQ_READ: n_state = S_READ;
                        REQ_FIND: n_state = i_status.count_zero ? S_OUT : S_SCAN;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_READ:  n_state = S_OUT;
            S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        o_valid = (r_state == S_OUT);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_req_type)
                        REQ_LOAD: o_cmd.load       = 1'b1;
                        REQ_READ: o_cmd.read_start = 1'b1;
                        REQ_FIND: begin
                            o_cmd.find_empty = i_status.count_zero;
                            o_cmd.scan_start = !i_status.count_zero;
                        end
                        default: o_cmd = '0;
                    endcase
                end
            end
            S_READ:  o_cmd.read_done  = 1'b1;
            S_SCAN:  o_cmd.scan_issue = 1'b1;
            S_DRAIN: o_cmd.find_done  = !i_status.pipe_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[design/nps_datapath.sv]
`default_nettype none

module nps_datapath #(
    parameter int PALETTE_DEPTH = nps_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [nps_pkg::NUM_COLORS_W-1:0]   i_cfg_data,
    input  wire logic [nps_pkg::CHAN_W-1:0]         i_index,
    input  wire logic [nps_pkg::CHAN_W-1:0]         i_red,
    input  wire logic [nps_pkg::CHAN_W-1:0]         i_green,
    input  wire logic [nps_pkg::CHAN_W-1:0]         i_blue,
    input  wire nps_pkg::t_cmd                      i_cmd,
    output nps_pkg::t_status                        o_status,
    output logic      [nps_pkg::CHAN_W-1:0]         o_color_index,
    output logic                                    o_exact_match,
    output logic      [nps_pkg::CHAN_W-1:0]         o_red_out,
    output logic      [nps_pkg::CHAN_W-1:0]         o_green_out,
    output logic      [nps_pkg::CHAN_W-1:0]         o_blue_out
);

    import nps_pkg::*;

    localparam int AW      = $clog2(PALETTE_DEPTH);
    localparam int CNT_FULL = $clog2(PALETTE_DEPTH + 1);
    localparam int CNT_W   = (CNT_FULL < NUM_COLORS_W) ? CNT_FULL : NUM_COLORS_W;

    logic [NUM_COLORS_W-1:0] r_num_colors;
    logic [CNT_W-1:0]        count;

    logic [CHAN_W-1:0]       r_red;
    logic [CHAN_W-1:0]       r_green;
    logic [CHAN_W-1:0]       r_blue;
    logic [CHAN_W-1:0]       r_req_idx;
    logic                    r_read_ok;

    logic [CNT_W-1:0]        r_scan_cnt;
    logic                    r_issue_v;
    logic [CNT_W-1:0]        r_issue_idx;

    logic                    r_a_v;
    logic [CNT_W-1:0]        r_a_idx;
    logic [ENTRY_W-1:0]      r_a_col;
    logic [SQ_W-1:0]         r_sq_r;
    logic [SQ_W-1:0]         r_sq_g;
    logic [SQ_W-1:0]         r_sq_b;

    logic                    r_best_v;
    logic [DIST_W-1:0]       r_best_d;
    logic [CNT_W-1:0]        r_best_idx;
    logic [ENTRY_W-1:0]      r_best_col;

    logic                    load_ok;
    logic                    read_ok;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [ENTRY_W-1:0]      wdata;
    logic [CHAN_W-1:0]       d_r;
    logic [CHAN_W-1:0]       d_g;
    logic [CHAN_W-1:0]       d_b;
    logic [DIST_W-1:0]       cand_d;

    always_comb begin
        if (32'(r_num_colors) > PALETTE_DEPTH) begin
            count = CNT_W'(PALETTE_DEPTH);
        end else begin
            count = CNT_W'(r_num_colors);
        end
    end

    assign load_ok   = (32'(i_index) < PALETTE_DEPTH);
    assign read_ok   = (32'(i_index) < 32'(count));
    assign wdata     = {i_blue, i_green, i_red};
    assign ram_re    = i_cmd.scan_issue | (i_cmd.read_start & read_ok);
    assign ram_raddr = i_cmd.scan_issue ? AW'(r_scan_cnt) : AW'(i_index);

    nps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load & load_ok),
        .i_waddr (AW'(i_index)),
        .i_wdata (wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_status.count_zero = (count == '0);
    assign o_status.scan_last  = (r_scan_cnt == CNT_W'(count - CNT_W'(1)));
    assign o_status.pipe_busy  = r_issue_v | r_a_v;

    always_comb begin
        d_r = (ram_rdata[7:0] > r_red) ? (ram_rdata[7:0] - r_red)
                                       : (r_red - ram_rdata[7:0]);
        d_g = (ram_rdata[15:8] > r_green) ? (ram_rdata[15:8] - r_green)
                                          : (r_green - ram_rdata[15:8]);
        d_b = (ram_rdata[23:16] > r_blue) ? (ram_rdata[23:16] - r_blue)
                                          : (r_blue - ram_rdata[23:16]);
        cand_d = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_colors <= '0;
            r_issue_v    <= 1'b0;
            r_a_v        <= 1'b0;
            r_best_v     <= 1'b0;
            r_scan_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_num_colors <= i_cfg_data;
            end
            r_issue_v <= i_cmd.scan_issue;
            r_a_v     <= r_issue_v;
            if (i_cmd.scan_start) begin
                r_scan_cnt <= '0;
                r_best_v   <= 1'b0;
            end else begin
                if (i_cmd.scan_issue) begin
                    r_scan_cnt <= r_scan_cnt + CNT_W'(1);
                end
                if (r_a_v) begin
                    r_best_v <= 1'b1;
                end
            end
        end
    end

    // Request capture, distance pipeline and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read_start || i_cmd.scan_start) begin
            r_req_idx <= i_index;
            r_red     <= i_red;
            r_green   <= i_green;
            r_blue    <= i_blue;
            r_read_ok <= read_ok;
        end

        r_issue_idx <= r_scan_cnt;

        r_a_idx <= r_issue_idx;
        r_a_col <= ram_rdata;
        r_sq_r  <= SQ_W'(d_r) * SQ_W'(d_r);
        r_sq_g  <= SQ_W'(d_g) * SQ_W'(d_g);
        r_sq_b  <= SQ_W'(d_b) * SQ_W'(d_b);

        // Strict compare keeps the lowest index among equal distances.
        if (r_a_v && (!r_best_v || (cand_d < r_best_d))) begin
            r_best_d   <= cand_d;
            r_best_idx <= r_a_idx;
            r_best_col <= r_a_col;
        end

        if (i_cmd.read_done) begin
            o_color_index <= r_req_idx;
            o_exact_match <= 1'b0;
            o_red_out     <= r_read_ok ? ram_rdata[7:0]   : '0;
            o_green_out   <= r_read_ok ? ram_rdata[15:8]  : '0;
            o_blue_out    <= r_read_ok ? ram_rdata[23:16] : '0;
        end else if (i_cmd.find_empty) begin
            o_color_index <= '0;
            o_exact_match <= 1'b0;
            o_red_out     <= '0;
            o_green_out   <= '0;
            o_blue_out    <= '0;
        end else if (i_cmd.find_done) begin
            o_color_index <= CHAN_W'(r_best_idx);
            o_exact_match <= (r_best_d == '0);
            o_red_out     <= r_best_col[7:0];
            o_green_out   <= r_best_col[15:8];
            o_blue_out    <= r_best_col[23:16];
        end
    end

endmodule

`default_nettype wire

[design/nearest_palette_color_search.sv]
`default_nettype none
// Load: no result; the next request is taken in the following cycle.
// Read: one memory read, then the result is registered and valid in the output state.
// Find: N entries are scanned one entry per cycle, N being num_colors limited to the palette
// depth; the result is registered when the pipeline drains; an empty palette answers next cycle.
// A result blocks new requests until it is taken; the block then returns to idle in the next cycle.
// Synchronous active-low reset clears the color count and control; the palette is not cleared.
module nearest_palette_color_search #(
    parameter int PALETTE_DEPTH = nps_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [nps_pkg::NUM_COLORS_W-1:0]   i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [nps_pkg::REQ_W-1:0]          i_req_type,
    input  wire logic [nps_pkg::CHAN_W-1:0]         i_index,
    input  wire logic [nps_pkg::CHAN_W-1:0]         i_red,
    input  wire logic [nps_pkg::CHAN_W-1:0]         i_green,
    input  wire logic [nps_pkg::CHAN_W-1:0]         i_blue,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic      [nps_pkg::CHAN_W-1:0]         o_color_index,
    output logic                                    o_exact_match,
    output logic      [nps_pkg::CHAN_W-1:0]         o_red_out,
    output logic      [nps_pkg::CHAN_W-1:0]         o_green_out,
    output logic      [nps_pkg::CHAN_W-1:0]         o_blue_out
);

    import nps_pkg::*;

    t_cmd    cmd;
    t_status status;

    nps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    nps_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_index       (i_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_color_index (o_color_index),
        .o_exact_match (o_exact_match),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out)
    );

`ifndef SYNTHESIS
    // A pending result holds off new requests.
    a_result_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request accepted while a result is pending");

    // A load never produces a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_req_type == REQ_LOAD) |=> !o_valid)
        else $error("load request produced a result");

    // A read answers after exactly one memory access.
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_req_type == REQ_READ) |=> ##1 o_valid)
        else $error("read result not delivered on time");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
module tb;
    import nps_pkg::*;

    localparam int DEPTH         = PALETTE_DEPTH_DEF;
    localparam int DEPTH_AW      = $clog2(DEPTH);
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;

    // A request code that the block ignores.
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SOME,
        STALL_MOST
    } t_stall_mode;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [CHAN_W-1:0] index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_color_req;

    typedef struct packed {
        logic [CHAN_W-1:0] index;
        logic              exact;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_color_ans;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [NUM_COLORS_W-1:0] i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [REQ_W-1:0]        i_req_type = REQ_NONE;
    logic [CHAN_W-1:0]       i_index = '0;
    logic [CHAN_W-1:0]       i_red = '0;
    logic [CHAN_W-1:0]       i_green = '0;
    logic [CHAN_W-1:0]       i_blue = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [CHAN_W-1:0]       o_color_index;
    logic                    o_exact_match;
    logic [CHAN_W-1:0]       o_red_out;
    logic [CHAN_W-1:0]       o_green_out;
    logic [CHAN_W-1:0]       o_blue_out;

    nearest_palette_color_search #(
        .PALETTE_DEPTH(DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req_type(i_req_type),
        .i_index(i_index),
        .i_red(i_red),
        .i_green(i_green),
        .i_blue(i_blue),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_color_index(o_color_index),
        .o_exact_match(o_exact_match),
        .o_red_out(o_red_out),
        .o_green_out(o_green_out),
        .o_blue_out(o_blue_out)
    );

    // Palette copies are stored as {blue, green, red}.
    logic [ENTRY_W-1:0] palette_model [DEPTH];
    logic [ENTRY_W-1:0] plan_palette [DEPTH];
    int unsigned        active_colors = 0;

    t_color_req pending_reqs [$];
    t_color_ans expected_colors [$];
    t_color_req next_req;

    bit          req_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    int unsigned cycle_count = 0;
    int unsigned results_seen = 0;
    int unsigned failures = 0;
    int unsigned n_loads = 0;
    int unsigned n_finds = 0;
    int unsigned n_reads = 0;
    int unsigned n_ignored = 0;
    int unsigned n_exact = 0;
    int unsigned n_settings = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned chan_sq(input logic [CHAN_W-1:0] a,
                                            input logic [CHAN_W-1:0] b);
        int unsigned d;
        d = (a > b) ? int'(a - b) : int'(b - a);
        return d * d;
    endfunction

    task automatic predict_request(input t_color_req req);
        t_color_ans         ans;
        logic [ENTRY_W-1:0] c;
        int unsigned        best;
        int unsigned        cand_d;
        int unsigned        best_idx;
        best = 32'hFFFF_FFFF;
        best_idx = 0;
        c = '0;
        case (req.kind)
            REQ_LOAD: begin
                palette_model[req.index] = {req.blue, req.green, req.red};
                n_loads++;
            end
            REQ_READ: begin
                if (req.index < active_colors) begin
                    c = palette_model[req.index];
                end
                ans.index = req.index;
                ans.exact = 1'b0;
                {ans.blue, ans.green, ans.red} = c;
                expected_colors.push_back(ans);
                n_reads++;
            end
            REQ_FIND: begin
                for (int unsigned k = 0; k < active_colors; k++) begin
                    cand_d = chan_sq(palette_model[k[DEPTH_AW-1:0]][7:0], req.red)
                           + chan_sq(palette_model[k[DEPTH_AW-1:0]][15:8], req.green)
                           + chan_sq(palette_model[k[DEPTH_AW-1:0]][23:16], req.blue);
                    // Strict compare keeps the lowest index on a tie.
                    if (cand_d < best) begin
                        best = cand_d;
                        best_idx = k;
                    end
                end
                if (active_colors != 0) begin
                    c = palette_model[best_idx[DEPTH_AW-1:0]];
                end
                ans.index = best_idx[CHAN_W-1:0];
                ans.exact = (active_colors != 0) && (best == 0);
                {ans.blue, ans.green, ans.red} = c;
                expected_colors.push_back(ans);
                n_finds++;
                if (ans.exact) begin
                    n_exact++;
                end
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    // Request acceptance feeds the predictor; result acceptance is checked here.
    always @(posedge i_clk) begin
        t_color_req req;
        t_color_ans want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_colors.size());
            $display("status: fail");
            $finish;
        end
        req_taken = i_rst_n && i_valid && !o_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected result, index %0d", $time, o_color_index);
                failures++;
            end else begin
                want = expected_colors.pop_front();
                check_field("color_index", 32'(want.index), 32'(o_color_index));
                check_field("exact_match", 32'(want.exact), 32'(o_exact_match));
                check_field("red_out", 32'(want.red), 32'(o_red_out));
                check_field("green_out", 32'(want.green), 32'(o_green_out));
                check_field("blue_out", 32'(want.blue), 32'(o_blue_out));
            end
        end
        if (req_taken) begin
            req.kind = i_req_type;
            req.index = i_index;
            req.red = i_red;
            req.green = i_green;
            req.blue = i_blue;
            predict_request(req);
        end
    end

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (gap_left > 0 || pending_reqs.size() == 0) begin
                i_valid <= 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end
            end else begin
                next_req = pending_reqs.pop_front();
                i_valid <= 1'b1;
                i_req_type <= next_req.kind;
                i_index <= next_req.index;
                i_red <= next_req.red;
                i_green <= next_req.green;
                i_blue <= next_req.blue;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 16);
                    if ($urandom_range(0, 2) == 0) begin
                        gap_left = 0;
                    end else if ($urandom_range(0, 9) == 0) begin
                        gap_left = $urandom_range(5, 30);
                    end else begin
                        gap_left = $urandom_range(1, 4);
                    end
                end
            end
        end
    end

    // Result receiver: stall pattern changes mode at random intervals, and once
    // it holds off for a long stretch so the block backs up into its input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (!hold_done && results_seen >= 150) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(10, 80);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE: i_stall <= 1'b0;
                STALL_SOME: i_stall <= 1'($urandom_range(0, 1));
                default:    i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [CHAN_W-1:0] idx,
                             input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b);
        t_color_req req;
        req.kind = kind;
        req.index = idx;
        req.red = r;
        req.green = g;
        req.blue = b;
        pending_reqs.push_back(req);
        if (kind == REQ_LOAD) begin
            plan_palette[idx] = {b, g, r};
        end
    endtask

    function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] v);
        int d;
        int t;
        d = $urandom_range(0, 6);
        t = int'(v) + d - 3;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return t[CHAN_W-1:0];
    endfunction

    function automatic logic [CHAN_W-1:0] rail();
        return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
    endfunction

    task automatic add_random_req(input int unsigned active);
        int unsigned        pick;
        int unsigned        sel;
        logic [CHAN_W-1:0]  idx;
        logic [ENTRY_W-1:0] c;
        pick = $urandom_range(0, 99);
        idx = CHAN_W'($urandom_range(0, 255));
        c = ENTRY_W'($urandom);
        if (active > 0 && $urandom_range(0, 1) == 1) begin
            idx = CHAN_W'($urandom_range(0, active - 1));
        end
        if (pick < 25) begin
            // Now and then copy another entry so that finds meet ties.
            if ($urandom_range(0, 4) == 0) begin
                c = plan_palette[DEPTH_AW'($urandom_range(0, DEPTH - 1))];
            end
            queue_req(REQ_LOAD, idx, c[7:0], c[15:8], c[23:16]);
        end else if (pick < 65) begin
            sel = $urandom_range(0, 3);
            if (active > 0 && sel == 1) begin
                c = plan_palette[DEPTH_AW'($urandom_range(0, active - 1))];
            end else if (active > 0 && sel == 2) begin
                c = plan_palette[DEPTH_AW'($urandom_range(0, active - 1))];
                c = {nudge(c[23:16]), nudge(c[15:8]), nudge(c[7:0])};
            end else if (sel == 3) begin
                c = {rail(), rail(), rail()};
            end
            queue_req(REQ_FIND, CHAN_W'($urandom_range(0, 255)), c[7:0], c[15:8], c[23:16]);
        end else if (pick < 95) begin
            // Reads around the count boundary hit both sides of the range check.
            if ($urandom_range(0, 3) == 0) begin
                idx = CHAN_W'(active + $urandom_range(0, 2) - 1);
            end
            queue_req(REQ_READ, idx, c[7:0], c[15:8], c[23:16]);
        end else begin
            queue_req(REQ_NONE, idx, c[7:0], c[15:8], c[23:16]);
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || i_valid || expected_colors.size() != 0) begin
            @(posedge i_clk);
        end
        // A trailing load gives no result, so let the block settle back to idle.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_num_colors(input logic [NUM_COLORS_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        active_colors = (value > DEPTH) ? DEPTH : value;
        n_settings++;
    endtask

    initial begin
        int unsigned fixed_counts [6] = '{256, 0, 1, 511, 2, 255};
        int unsigned count;
        int unsigned active;
        int unsigned n_items;

        for (int k = 0; k < DEPTH; k++) begin
            palette_model[k[DEPTH_AW-1:0]] = '0;
            plan_palette[k[DEPTH_AW-1:0]] = '0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The count is zero out of reset: empty find, reads out of range, ignored code, then eight loads.
        queue_req(REQ_FIND, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_req(REQ_READ, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_req(REQ_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_req(REQ_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_req(REQ_LOAD, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_req(REQ_LOAD, 8'd1, 8'd255, 8'd255, 8'd255);
        queue_req(REQ_LOAD, 8'd2, 8'd255, 8'd0, 8'd0);
        queue_req(REQ_LOAD, 8'd3, 8'd0, 8'd255, 8'd0);
        queue_req(REQ_LOAD, 8'd4, 8'd0, 8'd0, 8'd255);
        queue_req(REQ_LOAD, 8'd5, 8'd255, 8'd0, 8'd0);
        queue_req(REQ_LOAD, 8'd6, 8'd18, 8'd52, 8'd86);
        queue_req(REQ_LOAD, 8'd7, 8'd128, 8'd128, 8'd128);

        // Eight entries with a duplicate pair: exact hits, ties, a blue-only target.
        set_num_colors(9'd8);
        queue_req(REQ_FIND, 8'hFF, 8'd255, 8'd0, 8'd0);
        queue_req(REQ_FIND, 8'h00, 8'd255, 8'd255, 8'd255);
        queue_req(REQ_FIND, 8'h00, 8'd0, 8'd0, 8'd0);
        queue_req(REQ_FIND, 8'h00, 8'd250, 8'd5, 8'd3);
        queue_req(REQ_FIND, 8'h00, 8'd0, 8'd0, 8'd200);
        queue_req(REQ_FIND, 8'h00, 8'd18, 8'd52, 8'd87);
        queue_req(REQ_FIND, 8'h00, 8'd130, 8'd120, 8'd128);
        queue_req(REQ_READ, 8'd7, 8'd0, 8'd0, 8'd0);
        queue_req(REQ_READ, 8'd8, 8'd0, 8'd0, 8'd0);
        queue_req(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0);

        set_num_colors(9'd1);
        queue_req(REQ_FIND, 8'h00, 8'd255, 8'd255, 8'd255);
        queue_req(REQ_READ, 8'd1, 8'd0, 8'd0, 8'd0);

        // Fill the whole palette so that any later count only reaches loaded entries.
        for (int k = 0; k < DEPTH; k++) begin
            queue_req(REQ_LOAD, k[CHAN_W-1:0], CHAN_W'($urandom_range(0, 255)),
                      CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
        end

        for (int p = 0; p < 14; p++) begin
            count = (p < 6) ? fixed_counts[p] : $urandom_range(3, 40);
            set_num_colors(count[NUM_COLORS_W-1:0]);
            active = (count > DEPTH) ? DEPTH : count;
            // Full scans are slow, so large counts get short phases.
            n_items = (active >= 100) ? 40 : 85;
            for (int k = 0; k < n_items; k++) begin
                add_random_req(active);
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d loads, %0d finds (%0d exact), %0d reads, %0d ignored requests.",
                 n_loads, n_finds, n_exact, n_reads, n_ignored);
        $display("Checked %0d results across %0d color-count settings in %0d cycles.",
                 results_seen, n_settings, cycle_count);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
